// ===== design/kspf_pkg.sv =====
// ============================================================================
// kspf_pkg
// Shared types and codes for the k-mer SNP proximity filter: word formats,
// state encoding, and the command and status groups between control and data.
// ============================================================================
package kspf_pkg;

  localparam int MAP_ADDR_W = 20;
  localparam int MAP_LEN_W  = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MAP_WORD_W = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIG_POS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIG_FLAG    = 2'd2;

  // Operation codes of an input word.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [MAP_ADDR_W-1:0] map_address;
    logic                  map_mark;
    logic [63:0]           kmer_code;
    logic [31:0]           ref_position;
    logic [7:0]            ambiguity_flag;
  } in_word_t;

  typedef struct packed {
    logic [63:0] kept_kmer;
    logic [31:0] kept_position;
    logic [7:0]  kept_flag;
    logic [31:0] kept_total;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_READ,
    ST_LOAD_WRITE,
    ST_SETUP,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT
  } kspf_state_t;

  typedef struct packed {
    logic capture;     // take the input word into the item register
    logic load_read;   // read the bitmap word of the load address
    logic load_write;  // write back the updated bitmap word
    logic setup;       // compute window bounds and code matches
    logic scan_issue;  // read the next bitmap word of the window
    logic emit;        // load the output register and bump the count
  } kspf_cmd_t;

  typedef struct packed {
    logic load_in_range; // load address lies inside the map
    logic code_hit;      // position or flag matches an ambiguity code
    logic in_map;        // position lies below the effective map length
    logic last_word;     // the word being issued is the last of the window
    logic hit_now;       // a set bit was found in the window so far
    logic out_free;      // the output register can take a word this cycle
  } kspf_status_t;

endpackage

// ===== design/kmer_snp_proximity_filter.sv =====
// ============================================================================
// kmer_snp_proximity_filter
// Keeps reference dictionary entries that are ambiguous or lie near a SNP
// recorded in an on-chip position bitmap, and tags each kept entry with a
// running count.
// ============================================================================
//
//  Channel   Direction  Handshake          Word
//  in_       input      in_valid/in_stall  in_word_t: load or filter item
//  out_      output     out_valid/out_stall out_word_t: kept entry and count
//  cfg_      input      cfg_we             map length, ambiguity codes
//
// A load word steps through accept, bitmap word read and write back. A filter word
// steps through accept and setup, then goes to emit when an ambiguity code keeps it,
// ends when its position lies outside the map, and else reads each window word (three
// or four 64-bit words for READ_LENGTH = 100 unclipped), then emits if a bit was set.
// Reset is synchronous; it clears control state, the count and the output valid flag,
// and sets the configuration registers to their defaults. in_stall is low only while idle;
// a kept word also waits for a free output register.
// Each input word selects by its operation field: a load word sets or clears
// one bitmap position, a filter word tests its entry. An entry is kept when its
// position equals the ambiguous position code, when its flag equals the
// ambiguous flag code, or when a bitmap bit is set between position minus
// (READ_LENGTH-32) and position plus (READ_LENGTH-1), with the window clipped
// to the loaded map length.
module kmer_snp_proximity_filter
  import kspf_pkg::*;
#(
  parameter int unsigned     READ_LENGTH = 100,
  parameter longint unsigned MAP_DEPTH   = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  kspf_cmd_t    cmd;
  kspf_status_t status;

  // The sequencer owns the input handshake and issues at most one command per cycle.
  kspf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_word.operation),
    .status       (status),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // The datapath holds the bitmap, the window logic and the output register.
  kspf_dp #(
    .READ_LENGTH (READ_LENGTH),
    .MAP_DEPTH   (MAP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== design/kspf_ram.sv =====
// ============================================================================
// kspf_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kspf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kspf_ctrl.sv =====
// ============================================================================
// kspf_ctrl
// Sequencer of the filter: steps one word through load or window scan.
// ============================================================================
module kspf_ctrl
  import kspf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_operation,
  input  kspf_status_t status,
  output logic         in_stall,
  output kspf_cmd_t    cmd
);

  kspf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == OP_LOAD) ? ST_LOAD_READ : ST_SETUP;
        end
      end
      ST_LOAD_READ:  state_nxt = ST_LOAD_WRITE;
      ST_LOAD_WRITE: state_nxt = ST_IDLE;
      ST_SETUP: begin
        priority if (status.code_hit) begin
          state_nxt = ST_EMIT;
        end else if (status.in_map) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.last_word) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = status.hit_now ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD_READ:  cmd.load_read  = 1'b1;
      ST_LOAD_WRITE: cmd.load_write = status.load_in_range;
      ST_SETUP:      cmd.setup      = 1'b1;
      ST_SCAN:       cmd.scan_issue = 1'b1;
      ST_SCAN_END:   cmd            = '0;
      ST_EMIT:       cmd.emit       = status.out_free;
      default:       cmd            = '0;
    endcase
  end

endmodule

// ===== design/kspf_dp.sv =====
// ============================================================================
// kspf_dp
// Datapath: configuration registers, item register, bitmap memory, window
// bounds, masked word test, kept counter and output register.
// ============================================================================
module kspf_dp
  import kspf_pkg::*;
#(
  parameter int unsigned     READ_LENGTH = 100,
  parameter longint unsigned MAP_DEPTH   = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_word,
  input  kspf_cmd_t             cmd,
  output kspf_status_t          status,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_word_t             out_word
);

  // Only addresses below 2**20 can ever be written or read.
  localparam longint unsigned MAP_WORDS = (MAP_DEPTH + 64'd63) / 64'd64;
  localparam int MEM_WORDS = (MAP_WORDS < 64'd16384) ? int'(MAP_WORDS) : 16384;
  localparam int WAW       = $clog2(MEM_WORDS);
  localparam logic [MAP_ADDR_W-1:0] BEFORE = MAP_ADDR_W'(READ_LENGTH - 32);
  localparam logic [MAP_LEN_W:0]    AFTER  = (MAP_LEN_W + 1)'(READ_LENGTH - 1);
  localparam logic [MAP_LEN_W-1:0]  LEN_CAP =
    (MAP_DEPTH < 64'd2097152) ? MAP_LEN_W'(MAP_DEPTH) : '1;

  logic [MAP_LEN_W-1:0]  len_eff_r;
  logic [31:0]           ambig_pos_r;
  logic [7:0]            ambig_flag_r;
  in_word_t              item_r;
  logic [MAP_ADDR_W-1:0] lo_r, hi_r;
  logic [WAW-1:0]        cur_w_r, pend_w_r;
  logic                  pend_r;
  logic                  hit_r, hit_nxt;
  logic [31:0]           kept_r, kept_nxt;
  logic                  out_valid_r;
  out_word_t             out_r;

  // Configuration registers; the map length is held already capped to the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_eff_r    <= '0;
      ambig_pos_r  <= '1;
      ambig_flag_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_LENGTH: begin
          len_eff_r <= (64'(cfg_wdata[MAP_LEN_W-1:0]) > MAP_DEPTH) ?
                       LEN_CAP : cfg_wdata[MAP_LEN_W-1:0];
        end
        REG_AMBIG_POS:  ambig_pos_r  <= cfg_wdata;
        REG_AMBIG_FLAG: ambig_flag_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
  end

  // Window bounds from the captured position.
  logic [MAP_ADDR_W-1:0] pos20, lo_c, hi_c;
  logic [MAP_LEN_W:0]    hi_raw;
  logic [MAP_LEN_W-1:0]  len_m1;

  always_comb begin
    pos20  = item_r.ref_position[MAP_ADDR_W-1:0];
    lo_c   = (pos20 > BEFORE) ? pos20 - BEFORE : '0;
    hi_raw = {2'b00, pos20} + AFTER;
    len_m1 = len_eff_r - MAP_LEN_W'(1);
    hi_c   = (hi_raw > {1'b0, len_m1}) ? len_m1[MAP_ADDR_W-1:0]
                                       : hi_raw[MAP_ADDR_W-1:0];
  end

  logic [WAW-1:0] lo_w, hi_w;
  assign lo_w = lo_r[WAW+5:6];
  assign hi_w = hi_r[WAW+5:6];

  // Bitmap memory: 64 positions per word.
  logic                  ram_we;
  logic [WAW-1:0]        ram_waddr, ram_raddr;
  logic [MAP_WORD_W-1:0] ram_wdata, ram_rdata, bit_sel;

  assign bit_sel   = MAP_WORD_W'(1) << item_r.map_address[5:0];
  assign ram_we    = cmd.load_write;
  assign ram_waddr = item_r.map_address[WAW+5:6];
  assign ram_wdata = item_r.map_mark ? (ram_rdata | bit_sel) : (ram_rdata & ~bit_sel);
  assign ram_raddr = cmd.load_read ? item_r.map_address[WAW+5:6] : cur_w_r;

  kspf_ram #(
    .WIDTH (MAP_WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Test of the word that returned from the memory this cycle.
  logic [5:0]            lo_b, hi_b;
  logic [MAP_WORD_W-1:0] mask;

  always_comb begin
    lo_b    = (pend_w_r == lo_w) ? lo_r[5:0] : 6'd0;
    hi_b    = (pend_w_r == hi_w) ? hi_r[5:0] : 6'd63;
    mask    = ({MAP_WORD_W{1'b1}} << lo_b) & ({MAP_WORD_W{1'b1}} >> (6'd63 - hi_b));
    hit_nxt = hit_r | (pend_r & (|(ram_rdata & mask)));
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lo_r    <= lo_c;
      hi_r    <= hi_c;
      cur_w_r <= lo_c[WAW+5:6];
      hit_r   <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        cur_w_r <= cur_w_r + WAW'(1);
      end
      hit_r <= hit_nxt;
    end
    pend_w_r <= cur_w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_issue;
    end
  end

  // Kept counter and output register.
  assign kept_nxt = (kept_r == '1) ? kept_r : kept_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        kept_r      <= kept_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.kept_kmer     <= item_r.kmer_code;
      out_r.kept_position <= item_r.ref_position;
      out_r.kept_flag     <= item_r.ambiguity_flag;
      out_r.kept_total    <= kept_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    status.load_in_range = 64'(item_r.map_address) < MAP_DEPTH;
    status.code_hit      = (item_r.ref_position == ambig_pos_r) ||
                           (item_r.ambiguity_flag == ambig_flag_r);
    status.in_map        = item_r.ref_position < 32'(len_eff_r);
    status.last_word     = cur_w_r == hi_w;
    status.hit_now       = hit_nxt;
    status.out_free      = !out_valid_r || !out_stall;
  end

endmodule

// ===== design/kspf_checker.sv =====
// ============================================================================
// kspf_checker
// Port-level checks of the filter's sequencing, counting and output holding.
// ============================================================================
module kspf_checker
  import kspf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // One word at a time: the cycle after an accept the input is held off.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Reset leaves no word in the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A word that appears always carries a nonzero count.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word.kept_total != 32'd0)
    else $error("kept word with zero count");

  // A word that follows directly on a taken one counts up, or stays saturated.
  a_count_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 out_valid |->
      (out_word.kept_total == $past(out_word.kept_total) + 32'd1) ||
      (out_word.kept_total == 32'hFFFF_FFFF && $past(out_word.kept_total) == 32'hFFFF_FFFF))
    else $error("count did not advance between kept words");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule

bind kmer_snp_proximity_filter kspf_checker u_kspf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
